/* sv/bla_pkg.sv */
package bla_pkg;

    // Field widths of the channels.
    localparam int DIST_W    = 31;
    localparam int SPEED_W   = 31;
    localparam int HEIGHT_W  = 32;
    localparam int GRAV_W    = 22;
    localparam int STATUS_W  = 2;

    // Gravity after reset: 9.81 in unsigned Q6.16.
    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 22'd642908;

    // Normalised operands are below 2^30; the discriminant is below 2^62.
    localparam int NORM_W     = 30;
    localparam int DISC_W     = 62;
    localparam int ROOT_W     = 31;
    localparam int SQRT_STEPS = 31;

    typedef enum logic [STATUS_W-1:0] {
        ST_SOLVED     = 2'd0,
        ST_NO_ROOT    = 2'd1,
        ST_DEGENERATE = 2'd2
    } t_status;

    // Values that travel beside the square root pipeline.
    typedef struct packed {
        logic [NORM_W-1:0] p;
        logic [NORM_W-1:0] q;
        logic signed [63:0] y;
        t_status            status;
    } t_side;

    // Arctangent of 2^-i, scaled by 2^32 and rounded.
    function automatic logic [31:0] atan_entry(input int i);
        case (i)
            0:       atan_entry = 32'd3373259426;
            1:       atan_entry = 32'd1991351318;
            2:       atan_entry = 32'd1052175346;
            3:       atan_entry = 32'd534100635;
            4:       atan_entry = 32'd268086748;
            5:       atan_entry = 32'd134174063;
            6:       atan_entry = 32'd67103403;
            7:       atan_entry = 32'd33553749;
            8:       atan_entry = 32'd16777131;
            9:       atan_entry = 32'd8388597;
            10:      atan_entry = 32'd4194303;
            default: atan_entry = 32'(64'd1 << (32 - i));
        endcase
    endfunction

endpackage

/* sv/bla_in_if.sv */
interface bla_in_if import bla_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [DIST_W-1:0]          distance;
    logic [SPEED_W-1:0]         speed;
    logic signed [HEIGHT_W-1:0] height;

    modport source (output valid, distance, speed, height, input ready);
    modport sink   (input valid, distance, speed, height, output ready);
endinterface

/* sv/bla_cfg_if.sv */
interface bla_cfg_if import bla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GRAV_W-1:0] gravity;

    modport source (output valid, gravity, input ready);
    modport sink   (input valid, gravity, output ready);
endinterface

/* sv/bla_out_if.sv */
interface bla_out_if import bla_pkg::*; #(
    parameter int ANGLE_W = 18
) ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] launch_angle;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, launch_angle, status, input ready);
    modport sink   (input valid, launch_angle, status, output ready);
endinterface

/* sv/bla_front.sv */
module bla_front import bla_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [DIST_W-1:0]          i_distance,
    input  logic [SPEED_W-1:0]         i_speed,
    input  logic signed [HEIGHT_W-1:0] i_height,
    input  logic [GRAV_W-1:0]          i_gravity,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [DISC_W-1:0]          o_disc,
    output t_side                      o_side
);

    localparam int NS = 6;

    logic [NS-1:0] r_valid;
    logic [NS-1:0] n_valid;
    logic [NS-1:0] en;

    // Stage 1: captured operands.
    logic [DIST_W-1:0]  r1_d;
    logic [SPEED_W-1:0] r1_v;
    logic [31:0]        r1_hmag;
    logic               r1_hneg;
    logic [GRAV_W-1:0]  r1_g;
    logic               r1_zero;
    // Stage 2: full products.
    logic [61:0]        r2_p;
    logic [52:0]        r2_q;
    logic [53:0]        r2_r;
    logic               r2_hneg;
    logic               r2_zero;
    // Stage 3: normalising shift.
    logic [61:0]        r3_p;
    logic [52:0]        r3_q;
    logic [53:0]        r3_r;
    logic [5:0]         r3_s;
    logic               r3_hneg;
    logic               r3_zero;
    // Stage 4: normalised operands.
    logic [NORM_W-1:0]  r4_p;
    logic [NORM_W-1:0]  r4_q;
    logic signed [NORM_W:0] r4_r;
    logic               r4_zero;
    // Stage 5: squares and cross product.
    logic [59:0]        r5_pp;
    logic [59:0]        r5_qq;
    logic signed [61:0] r5_rp;
    logic [NORM_W-1:0]  r5_p;
    logic [NORM_W-1:0]  r5_q;
    logic               r5_zero;
    // Stage 6: discriminant and numerator.
    logic [DISC_W-1:0]  r6_disc;
    t_side              r6_side;

    logic [61:0]        m3;
    logic [5:0]         n_s;
    logic [NORM_W-1:0]  rmag4;
    logic signed [63:0] pp6;
    logic signed [63:0] qq6;
    logic signed [63:0] rp6;
    logic signed [63:0] disc6;

    // A stage moves on when it is empty or the next one moves on.
    always_comb begin
        en[NS-1] = !r_valid[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        n_valid = {r_valid[NS-2:0], i_valid};
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[NS-1];
    assign o_disc  = r6_disc;
    assign o_side  = r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    // Highest set bit at or above bit 30 sets the normalising shift.
    always_comb begin
        m3  = r2_p | 62'(r2_q) | 62'(r2_r);
        n_s = '0;
        for (int b = NORM_W; b < 62; b++) begin
            if (m3[b]) begin
                n_s = 6'(b - NORM_W + 1);
            end
        end
    end

    // Discriminant and numerator of the arctangent in exact integers.
    always_comb begin
        rmag4 = '0;
        pp6   = $signed(64'(r5_pp));
        qq6   = $signed(64'(r5_qq));
        rp6   = 64'(r5_rp) <<< 1;
        disc6 = pp6 - qq6 - rp6;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_d    <= i_distance;
            r1_v    <= i_speed;
            r1_hneg <= i_height[HEIGHT_W-1];
            r1_hmag <= i_height[HEIGHT_W-1] ? (~i_height + 32'd1) : i_height;
            r1_g    <= (i_gravity == '0) ? GRAV_W'(1) : i_gravity;
            r1_zero <= (i_distance == '0) || (i_speed == '0);
        end
        if (en[1]) begin
            r2_p    <= 62'(r1_v) * 62'(r1_v);
            r2_q    <= 53'(r1_g) * 53'(r1_d);
            r2_r    <= 54'(r1_g) * 54'(r1_hmag);
            r2_hneg <= r1_hneg;
            r2_zero <= r1_zero;
        end
        if (en[2]) begin
            r3_p    <= r2_p;
            r3_q    <= r2_q;
            r3_r    <= r2_r;
            r3_s    <= n_s;
            r3_hneg <= r2_hneg;
            r3_zero <= r2_zero;
        end
        if (en[3]) begin
            r4_p    <= NORM_W'(r3_p >> r3_s);
            r4_q    <= NORM_W'(r3_q >> r3_s);
            r4_r    <= r3_hneg ? -$signed({1'b0, NORM_W'(r3_r >> r3_s)})
                               : $signed({1'b0, NORM_W'(r3_r >> r3_s)});
            r4_zero <= r3_zero;
        end
        if (en[4]) begin
            r5_pp   <= 60'(r4_p) * 60'(r4_p);
            r5_qq   <= 60'(r4_q) * 60'(r4_q);
            r5_rp   <= 62'(r4_r) * $signed(62'(r4_p));
            r5_p    <= r4_p;
            r5_q    <= r4_q;
            r5_zero <= r4_zero;
        end
        if (en[5]) begin
            r6_side.p <= r5_p;
            r6_side.q <= r5_q;
            r6_side.y <= qq6 + rp6 + 64'(rmag4);
            if (r5_zero) begin
                r6_side.status <= ST_DEGENERATE;
                r6_disc        <= '0;
            end else if (disc6 < 0) begin
                r6_side.status <= ST_NO_ROOT;
                r6_disc        <= '0;
            end else begin
                r6_side.status <= ST_SOLVED;
                r6_disc        <= disc6[DISC_W-1:0];
            end
        end
    end

endmodule

/* sv/bla_sqrt.sv */
module bla_sqrt import bla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DISC_W-1:0] i_disc,
    input  t_side             i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    localparam int NS = SQRT_STEPS;

    logic [NS-1:0]     r_valid;
    logic [NS-1:0]     n_valid;
    logic [NS-1:0]     en;
    logic [DISC_W-1:0] r_rem  [NS];
    logic [DISC_W-1:0] r_root [NS];
    t_side             r_side [NS];
    logic [DISC_W-1:0] s_rem  [NS];
    logic [DISC_W-1:0] s_root [NS];
    t_side             s_side [NS];
    logic [DISC_W-1:0] n_rem  [NS];
    logic [DISC_W-1:0] n_root [NS];

    always_comb begin
        en[NS-1] = !r_valid[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        n_valid = {r_valid[NS-2:0], i_valid};
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[NS-1];
    assign o_root  = r_root[NS-1][ROOT_W-1:0];
    assign o_side  = r_side[NS-1];

    // One result bit per stage, from the top bit down.
    always_comb begin
        s_rem[0]  = i_disc;
        s_root[0] = '0;
        s_side[0] = i_side;
        for (int k = 1; k < NS; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_side[k] = r_side[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            if (s_rem[k] >= s_root[k] + (DISC_W'(1) << (2 * (NS - 1 - k)))) begin
                n_rem[k]  = s_rem[k] - s_root[k] - (DISC_W'(1) << (2 * (NS - 1 - k)));
                n_root[k] = (s_root[k] >> 1) + (DISC_W'(1) << (2 * (NS - 1 - k)));
            end else begin
                n_rem[k]  = s_rem[k];
                n_root[k] = s_root[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_side[k] <= s_side[k];
            end
        end
    end

endmodule

/* sv/bla_cordic.sv */
module bla_cordic import bla_pkg::*; #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ROOT_W-1:0]           i_root,
    input  t_side                       i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [FRAC_BITS+1:0] o_launch_angle,
    output logic [STATUS_W-1:0]         o_status
);

    localparam int N      = CORDIC_STEPS;
    localparam int NS     = N + 4;
    localparam int ANG_W  = FRAC_BITS + 2;
    localparam logic [63:0] HALF_PI_WIDE =
        (64'd2 * 64'(atan_entry(0)) + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [34:0] HALF_PI  = 35'(HALF_PI_WIDE);
    localparam logic signed [34:0] ROUND_UP = 35'(64'd1 << (31 - FRAC_BITS));
    localparam logic signed [ANG_W-1:0] MINUS_ONE = -(ANG_W'(1) << FRAC_BITS);

    logic [NS-1:0] r_valid;
    logic [NS-1:0] n_valid;
    logic [NS-1:0] en;

    // Stage 1: vector components.
    logic [61:0]       r1_x;
    logic [61:0]       r1_ay;
    logic              r1_yneg;
    t_status           r1_status;
    // Stage 2: normalising shift.
    logic [61:0]       r2_x;
    logic [61:0]       r2_ay;
    logic [5:0]        r2_t;
    logic              r2_yneg;
    logic              r2_degen;
    t_status           r2_status;
    // Stage 3: normalised vector.
    logic [NORM_W-1:0] r3_x;
    logic [NORM_W-1:0] r3_y;
    logic              r3_yneg;
    logic              r3_degen;
    t_status           r3_status;
    // Rotation stages.
    logic signed [33:0] r_cx [N];
    logic signed [33:0] r_cy [N];
    logic signed [34:0] r_cz [N];
    logic               r_yneg  [N];
    logic               r_degen [N];
    t_status            r_status [N];
    logic signed [33:0] s_cx [N];
    logic signed [33:0] s_cy [N];
    logic signed [34:0] s_cz [N];
    logic               s_yneg  [N];
    logic               s_degen [N];
    t_status            s_status [N];
    logic signed [33:0] n_cx [N];
    logic signed [33:0] n_cy [N];
    logic signed [34:0] n_cz [N];
    // Output register.
    logic signed [ANG_W-1:0] r_angle;
    t_status                 r_out_status;

    logic [31:0]        sum1;
    logic [61:0]        m2;
    logic [5:0]         n_t;
    logic signed [34:0] z_fin;
    logic signed [34:0] a_fin;
    logic signed [ANG_W-1:0] n_angle;

    always_comb begin
        en[NS-1] = !r_valid[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        n_valid = {r_valid[NS-2:0], i_valid};
    end

    assign o_ready        = en[0];
    assign o_valid        = r_valid[NS-1];
    assign o_launch_angle = r_angle;
    assign o_status       = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    // Shift that brings the larger component below 2^30.
    always_comb begin
        sum1 = 32'(i_side.p) + 32'(i_root);
        m2   = r1_x | r1_ay;
        n_t  = '0;
        for (int b = NORM_W; b < 62; b++) begin
            if (m2[b]) begin
                n_t = 6'(b - NORM_W + 1);
            end
        end
    end

    // Vectoring rotations: drive y to zero, adding up the angle.
    always_comb begin
        s_cx[0]     = $signed(34'(r3_x));
        s_cy[0]     = $signed(34'(r3_y));
        s_cz[0]     = '0;
        s_yneg[0]   = r3_yneg;
        s_degen[0]  = r3_degen;
        s_status[0] = r3_status;
        for (int k = 1; k < N; k++) begin
            s_cx[k]     = r_cx[k-1];
            s_cy[k]     = r_cy[k-1];
            s_cz[k]     = r_cz[k-1];
            s_yneg[k]   = r_yneg[k-1];
            s_degen[k]  = r_degen[k-1];
            s_status[k] = r_status[k-1];
        end
        for (int k = 0; k < N; k++) begin
            if (s_cy[k] >= 0) begin
                n_cx[k] = s_cx[k] + (s_cy[k] >>> k);
                n_cy[k] = s_cy[k] - (s_cx[k] >>> k);
                n_cz[k] = s_cz[k] + $signed(35'(atan_entry(k)));
            end else begin
                n_cx[k] = s_cx[k] - (s_cy[k] >>> k);
                n_cy[k] = s_cy[k] + (s_cx[k] >>> k);
                n_cz[k] = s_cz[k] - $signed(35'(atan_entry(k)));
            end
        end
    end

    // Sign, rounding to the output scale and clamping to a quarter turn.
    always_comb begin
        z_fin = r_yneg[N-1] ? -r_cz[N-1] : r_cz[N-1];
        a_fin = (z_fin + ROUND_UP) >>> (32 - FRAC_BITS);
        if (r_status[N-1] != ST_SOLVED) begin
            n_angle = MINUS_ONE;
        end else if (r_degen[N-1]) begin
            n_angle = '0;
        end else if (a_fin > HALF_PI) begin
            n_angle = ANG_W'(HALF_PI);
        end else if (a_fin < -HALF_PI) begin
            n_angle = ANG_W'(-HALF_PI);
        end else begin
            n_angle = ANG_W'(a_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_x      <= 62'(i_side.q) * 62'(sum1);
            r1_ay     <= i_side.y[63] ? 62'(-i_side.y) : 62'(i_side.y);
            r1_yneg   <= i_side.y[63];
            r1_status <= i_side.status;
        end
        if (en[1]) begin
            r2_x      <= r1_x;
            r2_ay     <= r1_ay;
            r2_t      <= n_t;
            r2_yneg   <= r1_yneg;
            r2_degen  <= (r1_x == '0) && (r1_ay == '0);
            r2_status <= r1_status;
        end
        if (en[2]) begin
            r3_x      <= NORM_W'(r2_x >> r2_t);
            r3_y      <= NORM_W'(r2_ay >> r2_t);
            r3_yneg   <= r2_yneg;
            r3_degen  <= r2_degen;
            r3_status <= r2_status;
        end
        for (int k = 0; k < N; k++) begin
            if (en[3+k]) begin
                r_cx[k]     <= n_cx[k];
                r_cy[k]     <= n_cy[k];
                r_cz[k]     <= n_cz[k];
                r_yneg[k]   <= s_yneg[k];
                r_degen[k]  <= s_degen[k];
                r_status[k] <= s_status[k];
            end
        end
        if (en[NS-1]) begin
            r_angle      <= n_angle;
            r_out_status <= r_status[N-1];
        end
    end

endmodule

/* sv/ballistic_launch_angle_unit.sv */
// Lower launch angle of a drag-free projectile.
// An item on i_in carries distance, speed and target height in fixed point
// with sixteen fraction bits; each one gives one item on o_out holding the
// launch angle in radians and a status: solved, no real solution (angle -1.0)
// or zero distance or speed (angle -1.0).
// i_cfg writes the gravity register; it is always ready and should be
// written only while no item is in flight. Reset loads 9.81 m/s^2.
// Items pass through products and normalisation, a square root stage for
// each bit of the 31-bit root, and CORDIC_STEPS rotations with the stages
// around them. Throughput is one item per cycle while o_out.ready is high;
// every stage holds one item and the square root and rotation stages set
// the depth.
// When the receiver holds o_out.ready low, items pile up in the stages;
// i_in.ready stays high while any stage is still empty, so nothing is lost
// or repeated. Reset empties the pipeline and restores the gravity value.
module ballistic_launch_angle_unit import bla_pkg::*; #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bla_in_if.sink     i_in,
    bla_cfg_if.sink    i_cfg,
    bla_out_if.source  o_out
);

    logic [GRAV_W-1:0] r_gravity;

    logic              f_valid;
    logic              f_ready;
    logic [DISC_W-1:0] f_disc;
    t_side             f_side;
    logic              q_valid;
    logic              q_ready;
    logic [ROOT_W-1:0] q_root;
    t_side             q_side;

    // Gravity register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
        end else if (i_cfg.valid) begin
            r_gravity <= i_cfg.gravity;
        end
    end

    bla_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_distance (i_in.distance),
        .i_speed    (i_in.speed),
        .i_height   (i_in.height),
        .i_gravity  (r_gravity),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_disc     (f_disc),
        .o_side     (f_side)
    );

    bla_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_disc  (f_disc),
        .i_side  (f_side),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    bla_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_ready        (q_ready),
        .i_root         (q_root),
        .i_side         (q_side),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_launch_angle (o_out.launch_angle),
        .o_status       (o_out.status)
    );

endmodule
